[design/kbpi_pkg.sv]
package kbpi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CORDIC_ITERS = 16;
  localparam int IDX_W = 5;
  localparam int CW = 34;
  localparam int NUM_W = 56;
  localparam int DEN_W = 32;
  localparam int POS_W = 48;
  localparam int HEAD_W = 19;

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] STEER_LIM_Q30 = 34'sd1503238554;
  localparam logic [23:0] MIN_AXLE = 24'd655;
  localparam logic [HEAD_W-1:0] HALF_TURN = 19'd205887;
  localparam logic [HEAD_W-1:0] FULL_TURN = 19'd411774;
  // floor(2^50 / FULL_TURN)
  localparam logic [31:0] WRAP_RECIP = 32'd2734266628;

  typedef struct packed {
    logic vld;
    logic tag;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cord_t;

  function automatic logic signed [CW-1:0] atan_q30(input logic [IDX_W-1:0] i);
    logic signed [CW-1:0] a;
    case (i)
      5'd0: a = 34'sd843314857;
      5'd1: a = 34'sd497837829;
      5'd2: a = 34'sd263043837;
      5'd3: a = 34'sd133525159;
      5'd4: a = 34'sd67021687;
      5'd5: a = 34'sd33543516;
      5'd6: a = 34'sd16775851;
      5'd7: a = 34'sd8388437;
      5'd8: a = 34'sd4194283;
      5'd9: a = 34'sd2097141;
      5'd10: a = 34'sd1048574;
      5'd11: a = 34'sd524287;
      5'd12: a = 34'sd262143;
      5'd13: a = 34'sd131071;
      5'd14: a = 34'sd65535;
      5'd15: a = 34'sd32767;
      5'd16: a = 34'sd16383;
      5'd17: a = 34'sd8191;
      5'd18: a = 34'sd4095;
      5'd19: a = 34'sd2047;
      5'd20: a = 34'sd1023;
      5'd21: a = 34'sd511;
      5'd22: a = 34'sd255;
      5'd23: a = 34'sd127;
      5'd24: a = 34'sd63;
      5'd25: a = 34'sd31;
      5'd26: a = 34'sd15;
      5'd27: a = 34'sd8;
      5'd28: a = 34'sd4;
      5'd29: a = 34'sd2;
      5'd30: a = 34'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[design/kbpi_cordic_cell.sv]
module kbpi_cordic_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [kbpi_pkg::IDX_W-1:0] idx,
  input  kbpi_pkg::cord_t          din,
  output kbpi_pkg::cord_t          dout
);
  import kbpi_pkg::*;

  cord_t res;
  logic signed [CW-1:0] xs, ys, at;

  always_comb begin
    xs = din.x >>> idx;
    ys = din.y >>> idx;
    at = atan_q30(idx);
    res = din;
    if (din.z >= 0) begin
      res.x = din.x - ys;
      res.y = din.y + xs;
      res.z = din.z - at;
    end else begin
      res.x = din.x + ys;
      res.y = din.y - xs;
      res.z = din.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.tag <= res.tag;
    dout.x <= res.x;
    dout.y <= res.y;
    dout.z <= res.z;
  end

endmodule

[design/kbpi_div.sv]
module kbpi_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [kbpi_pkg::NUM_W-1:0]   num,
  input  logic [kbpi_pkg::DEN_W-1:0]   den,
  output logic                         done,
  output logic [kbpi_pkg::NUM_W-1:0]   quo
);
  import kbpi_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic busy;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;

  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    diff = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      den_r <= den;
      quo <= num;
      rem <= '0;
    end else if (busy) begin
      if (!diff[DEN_W]) begin
        rem <= diff[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

[design/kinematic_bicycle_pose_integrator.sv]
// Path from the accepting edge to m_tvalid: heading and steer feed into the 16-cell CORDIC
// chain, the multiplies, two 56-step radix-2 divides and a reciprocal heading wrap.
// The two divides share one bit-serial divider.
// A new word is taken only once the previous result sits in the output register.
// Reset (rst, synchronous): pose cleared to zero, time_step 33554, axle_spacing 9830.
module kinematic_bicycle_pose_integrator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // speed[23:0], steer_angle[41:24], zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // pos_x[47:0], pos_y[95:48], heading[114:96], pad
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [23:0]  cfg_wdata
);
  import kbpi_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_STEER = 4'd1, S_CORD = 4'd2, S_MD = 4'd3,
                         S_MX = 4'd4, S_MY = 4'd5, S_D1 = 4'd6, S_W1 = 4'd7,
                         S_MT = 4'd8, S_D2 = 4'd9, S_W2 = 4'd10, S_Q1 = 4'd11,
                         S_Q2 = 4'd12, S_Q3 = 4'd13, S_OUT = 4'd14;
  localparam logic REG_STEP = 1'b0, REG_AXLE = 1'b1;

  logic [3:0] state;
  logic [23:0] time_step, axle_spacing;
  logic signed [POS_W-1:0] pose_x, pose_y;
  logic signed [HEAD_W-1:0] pose_heading;

  logic signed [23:0] v_r;
  logic signed [17:0] st_r;
  logic flip;
  logic signed [CW-1:0] hc, hs, sc, ss;
  logic [31:0] travel;
  logic [24:0] dxm, dym;
  logic [23:0] tanm;
  logic signed [50:0] hp;
  logic [63:0] prod;
  logic [31:0] mul_a, mul_b;

  cord_t chain [CORDIC_ITERS+1];
  logic signed [CW-1:0] hz, hz_f, sz;
  logic accept;

  logic div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;

  logic [CW-1:0] hc_m, hs_m, ss_m;
  logic signed [25:0] dx, dy;
  logic signed [POS_W:0] sx, sy;
  logic signed [POS_W-1:0] nx, ny;
  logic signed [50:0] hsum, hp_next;
  logic [47:0] rate;
  logic [HEAD_W-1:0] mrem, rwrap;
  logic signed [HEAD_W:0] hnew;
  logic [50:0] hp_mag;
  logic [34:0] rdiff;
  logic [19:0] rlow, rsub;

  assign accept = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= 24'd33554;
      axle_spacing <= 24'd9830;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_STEP: time_step <= cfg_wdata;
        REG_AXLE: axle_spacing <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // angle feed into the CORDIC row
  always_comb begin
    hz = CW'(pose_heading) <<< 14;
    if (hz > HALF_PI_Q30) hz_f = hz - PI_Q30;
    else if (hz < -HALF_PI_Q30) hz_f = hz + PI_Q30;
    else hz_f = hz;
    sz = CW'(st_r) <<< 14;
    if (sz > STEER_LIM_Q30) sz = STEER_LIM_Q30;
    if (sz < -STEER_LIM_Q30) sz = -STEER_LIM_Q30;
    chain[0].x = GAIN_Q30;
    chain[0].y = '0;
    if (state == S_STEER) begin
      chain[0].vld = 1'b1;
      chain[0].tag = 1'b1;
      chain[0].z = sz;
    end else begin
      chain[0].vld = accept;
      chain[0].tag = 1'b0;
      chain[0].z = hz_f;
    end
  end

  for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cell
    kbpi_cordic_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .idx  (IDX_W'(g)),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  kbpi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    hc_m = hc < 0 ? -hc : hc;
    hs_m = hs < 0 ? -hs : hs;
    ss_m = ss < 0 ? -ss : ss;
    hp_mag = hp[50] ? -hp : hp;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MD: begin
        mul_a = 32'(v_r < 0 ? -25'(v_r) : 25'(v_r));
        mul_b = 32'(time_step);
      end
      S_MX: begin
        mul_a = prod[47:16];
        mul_b = hc_m[31:0];
      end
      S_MY: begin
        mul_a = travel;
        mul_b = hs_m[31:0];
      end
      S_MT: begin
        mul_a = travel;
        mul_b = 32'(tanm);
      end
      // |hp| stays below 2^34: speed, time_step, the steering limit and MIN_AXLE bound the turn
      S_Q1: begin
        mul_a = hp_mag[33:2];
        mul_b = WRAP_RECIP;
      end
      S_Q2: begin
        mul_a = 32'(prod[63:48]);
        mul_b = 32'(FULL_TURN);
      end
      default: ;
    endcase

    dx = ((v_r < 0) != (hc < 0)) ? -26'(dxm) : 26'(dxm);
    dy = ((v_r < 0) != (hs < 0)) ? -26'(dym) : 26'(dym);
    sx = 49'(pose_x) + 49'(dx);
    sy = 49'(pose_y) + 49'(dy);
    if (sx[POS_W] != sx[POS_W-1]) nx = sx[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                                   : {1'b0, {(POS_W-1){1'b1}}};
    else nx = sx[POS_W-1:0];
    if (sy[POS_W] != sy[POS_W-1]) ny = sy[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                                   : {1'b0, {(POS_W-1){1'b1}}};
    else ny = sy[POS_W-1:0];

    rate = div_quo[55:8];
    hsum = ((v_r < 0) != (ss < 0)) ? 51'(pose_heading) - 51'(rate)
                                   : 51'(pose_heading) + 51'(rate);
    hp_next = hsum + 51'(HALF_TURN);

    // quotient estimate is exact or one low, so one correction step
    rdiff = hp_mag[34:0] - prod[34:0];
    rlow = rdiff[19:0];
    rsub = rlow - 20'(FULL_TURN);
    mrem = (rlow >= 20'(FULL_TURN)) ? rsub[HEAD_W-1:0] : rlow[HEAD_W-1:0];
    if (hp[50]) rwrap = (mrem == '0) ? '0 : FULL_TURN - mrem;
    else rwrap = mrem;
    hnew = $signed({1'b0, rwrap}) - $signed({1'b0, HALF_TURN});

    div_start = (state == S_D1) || (state == S_D2);
    div_num = '0;
    div_den = 32'd1;
    unique case (state)
      S_D1: begin
        div_num = NUM_W'(ss_m) << FRAC_BITS;
        div_den = (sc > 0) ? sc[31:0] : 32'd1;
      end
      S_D2: begin
        div_num = prod[NUM_W-1:0];
        div_den = 32'(axle_spacing < MIN_AXLE ? MIN_AXLE : axle_spacing);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      pose_x <= '0;
      pose_y <= '0;
      pose_heading <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            v_r <= s_tdata[23:0];
            st_r <= s_tdata[41:24];
            flip <= (hz > HALF_PI_Q30) || (hz < -HALF_PI_Q30);
            state <= S_STEER;
          end
        end
        S_STEER: state <= S_CORD;
        S_CORD: begin
          if (chain[CORDIC_ITERS].vld && !chain[CORDIC_ITERS].tag) begin
            hc <= flip ? -chain[CORDIC_ITERS].x : chain[CORDIC_ITERS].x;
            hs <= flip ? -chain[CORDIC_ITERS].y : chain[CORDIC_ITERS].y;
          end
          if (chain[CORDIC_ITERS].vld && chain[CORDIC_ITERS].tag) begin
            sc <= chain[CORDIC_ITERS].x;
            ss <= chain[CORDIC_ITERS].y;
            state <= S_MD;
          end
        end
        S_MD: state <= S_MX;
        S_MX: begin
          travel <= prod[47:16];
          state <= S_MY;
        end
        S_MY: begin
          dxm <= prod[62:38];
          state <= S_D1;
        end
        S_D1: begin
          dym <= prod[62:38];
          state <= S_W1;
        end
        S_W1: begin
          if (div_done) begin
            tanm <= div_quo[23:0];
            state <= S_MT;
          end
        end
        S_MT: begin
          pose_x <= nx;
          pose_y <= ny;
          state <= S_D2;
        end
        S_D2: state <= S_W2;
        S_W2: begin
          if (div_done) begin
            hp <= hp_next;
            state <= S_Q1;
          end
        end
        S_Q1: state <= S_Q2;
        S_Q2: state <= S_Q3;
        S_Q3: begin
          pose_heading <= hnew[HEAD_W-1:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {5'b0, pose_heading, pose_y, pose_x};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_steer: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_STEER)
    else $error("steer feed missed");

  a_chain_cord: assert property (@(posedge clk) disable iff (rst)
    chain[CORDIC_ITERS].vld |-> state == S_CORD)
    else $error("CORDIC result outside wait");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_W1 || state == S_W2))
    else $error("divider done outside wait");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[114:96]) >= -$signed({1'b0, HALF_TURN}) &&
                  $signed(m_tdata[114:96]) < $signed({1'b0, HALF_TURN})))
    else $error("heading out of range");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kbpi_pkg::*;

  localparam logic CFG_TIME_STEP = 1'b0;
  localparam logic CFG_AXLE = 1'b1;
  localparam longint POS_HI = 64'sh00007FFFFFFFFFFF;
  localparam longint POS_LO = -64'sh0000800000000000;
  localparam longint PI_Q = 64'sd3373259426;
  localparam longint HPI_Q = 64'sd1686629713;
  localparam longint STEER_LIM = 64'sd1503238554;
  localparam longint HALF_Q16 = 64'sd205887;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [119:0] m_tdata;
  logic cfg_we = 1'b0;
  logic cfg_addr = 1'b0;
  logic [23:0] cfg_wdata = '0;

  always #1 clk = ~clk;

  kinematic_bicycle_pose_integrator DUT (.*);

  typedef struct packed {
    logic signed [47:0] px;
    logic signed [47:0] py;
    logic signed [18:0] hd;
  } pose_t;

  typedef struct packed {
    logic signed [23:0] spd;
    logic signed [17:0] str;
    logic chk;
    pose_t want;
  } stim_t;

  pose_t pose_q[$];
  int errors = 0;
  int n_out = 0;

  longint unsigned step_sz, axle_len;
  longint cur_x, cur_y, cur_h;
  logic hold_off = 1'b0;
  logic start_hold = 1'b0;

  function automatic longint asr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  task automatic rotate(input longint ang, output longint c, output longint s);
    longint rx, ry, rz, nx;
    logic flip;
    rx = 64'sd652032874; ry = 0; rz = ang; flip = 1'b0;
    if (rz > HPI_Q) begin
      rz -= PI_Q; flip = 1'b1;
    end else if (rz < -HPI_Q) begin
      rz += PI_Q; flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (rz >= 0) begin
        nx = rx - asr(ry, i); ry = ry + asr(rx, i); rz -= longint'(atan_q30(i[4:0]));
      end else begin
        nx = rx + asr(ry, i); ry = ry - asr(rx, i); rz += longint'(atan_q30(i[4:0]));
      end
      rx = nx;
    end
    c = flip ? -rx : rx;
    s = flip ? -ry : ry;
  endtask

  function automatic longint clamp_pos(longint v);
    return v > POS_HI ? POS_HI : (v < POS_LO ? POS_LO : v);
  endfunction

  task automatic advance_pose(input logic signed [23:0] spd, input logic signed [17:0] str,
                              output pose_t p);
    longint hc, hs, sc, ss, v, st, dx, dy, dth, h, r;
    longint unsigned travel, tanm, len, rate;
    v = longint'(spd); st = longint'(str);
    rotate(cur_h <<< 14, hc, hs);
    st = st <<< 14;
    if (st > STEER_LIM) st = STEER_LIM;
    if (st < -STEER_LIM) st = -STEER_LIM;
    rotate(st, sc, ss);
    travel = (mag(v) * step_sz) >> 16;
    dx = longint'((travel * mag(hc)) >> 38);
    if ((v < 0) != (hc < 0)) dx = -dx;
    dy = longint'((travel * mag(hs)) >> 38);
    if ((v < 0) != (hs < 0)) dy = -dy;
    cur_x = clamp_pos(cur_x + dx);
    cur_y = clamp_pos(cur_y + dy);
    if (sc <= 0) sc = 1;
    tanm = (mag(ss) << 16) / longint'(sc);
    len = axle_len < 64'd655 ? 64'd655 : axle_len;
    rate = ((travel * tanm) / len) >> 8;
    dth = longint'(rate);
    if ((v < 0) != (ss < 0)) dth = -dth;
    h = cur_h + dth;
    r = (h + HALF_Q16) % (2 * HALF_Q16);
    if (r < 0) r += 2 * HALF_Q16;
    cur_h = r - HALF_Q16;
    p.px = cur_x[47:0]; p.py = cur_y[47:0]; p.hd = cur_h[18:0];
  endtask

  task automatic send_word(input logic signed [23:0] spd, input logic signed [17:0] str,
                           input logic chk, input pose_t want);
    pose_t p;
    s_tdata <= {6'd0, str, spd};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_pose(spd, str, p);
    if (chk && p != want) begin
      errors++;
      $display("%0t predictor row mismatch exp %h got %h", $time, want, p);
    end
    pose_q.push_back(p);
  endtask

  task automatic drop_valid();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (pose_q.size() != 0 && guard < 100000) begin
      @(posedge clk); guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] val);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TIME_STEP) step_sz = 64'(val); else axle_len = 64'(val);
    @(posedge clk);
  endtask

  // receiver
  always @(posedge clk) begin
    pose_t got, exp_p;
    if (!rst && m_tvalid && m_tready) begin
      got.px = m_tdata[47:0];
      got.py = m_tdata[95:48];
      got.hd = m_tdata[114:96];
      if (pose_q.size() == 0) begin
        errors++;
        $display("%0t unexpected word got %h", $time, got);
      end else begin
        exp_p = pose_q.pop_front();
        n_out++;
        if (got.px != exp_p.px) begin
          errors++; $display("%0t pos_x exp %h got %h", $time, exp_p.px, got.px);
        end
        if (got.py != exp_p.py) begin
          errors++; $display("%0t pos_y exp %h got %h", $time, exp_p.py, got.py);
        end
        if (got.hd != exp_p.hd) begin
          errors++; $display("%0t heading exp %h got %h", $time, exp_p.hd, got.hd);
        end
      end
    end
    if (hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 3) != 0) || (n_out % 64 < 16);
  end

  // receiver long hold-off
  initial begin
    wait (start_hold);
    hold_off = 1'b1;
    repeat (2000) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    stim_t rows[$];
    pose_t z;
    int burst;
    logic signed [23:0] sp;
    logic signed [17:0] sa;
    z = '0;
    step_sz = 33554; axle_len = 9830;
    cur_x = 0; cur_y = 0; cur_h = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back('{24'sd0, 18'sd0, 1'b1, z});
    rows.push_back('{24'sd0, 18'sd91750, 1'b1, z});
    rows.push_back('{24'sd8388607, 18'sd0, 1'b0, z});
    rows.push_back('{-24'sd8388608, 18'sd0, 1'b0, z});
    rows.push_back('{24'sd65536, 18'sd91750, 1'b0, z});
    rows.push_back('{24'sd65536, -18'sd91750, 1'b0, z});
    rows.push_back('{24'sd8388607, 18'sd131071, 1'b0, z});
    rows.push_back('{-24'sd8388608, -18'sd131072, 1'b0, z});
    rows.push_back('{24'sd8388607, 18'sd91750, 1'b0, z});
    rows.push_back('{24'sd8388607, 18'sd91750, 1'b0, z});
    rows.push_back('{-24'sd1, -18'sd1, 1'b0, z});
    foreach (rows[i]) begin
      send_word(rows[i].spd, rows[i].str, rows[i].chk, rows[i].want);
      drop_valid();
    end
    drain();

    write_reg(CFG_TIME_STEP, 24'd0);
    send_word(24'sd8388607, 18'sd91750, 1'b0, z);
    drop_valid();
    drain();
    write_reg(CFG_TIME_STEP, 24'hFFFFFF);
    write_reg(CFG_AXLE, 24'd0);
    for (int i = 0; i < 6; i++) begin
      send_word(24'sd8388607, (i % 2) ? 18'sd91750 : -18'sd91750, 1'b0, z);
    end
    drop_valid();
    drain();
    write_reg(CFG_AXLE, 24'hFFFFFF);
    for (int i = 0; i < 4; i++) send_word(-24'sd8388608, 18'sd91750, 1'b0, z);
    drop_valid();
    drain();

    // long receiver hold-off while words keep coming
    start_hold = 1'b1;
    for (int i = 0; i < 4; i++) send_word(24'($urandom), 18'($urandom), 1'b0, z);
    drop_valid();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_TIME_STEP, 24'd33554); write_reg(CFG_AXLE, 24'd9830); end
        1: begin write_reg(CFG_TIME_STEP, 24'd1); write_reg(CFG_AXLE, 24'd655); end
        2: begin write_reg(CFG_TIME_STEP, 24'hFFFFFF); write_reg(CFG_AXLE, 24'd654); end
        default: begin
          write_reg(CFG_TIME_STEP, 24'($urandom_range(1, 24'hFFFFFF)));
          write_reg(CFG_AXLE, 24'($urandom_range(0, 24'hFFFFFF)));
        end
      endcase
      for (int k = 0; k < 220; ) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst && k < 220; b++, k++) begin
          sp = 24'($urandom);
          if ($urandom_range(0, 3) == 0) sa = 18'($urandom);
          else sa = 18'($urandom_range(0, 183500) - 91750);
          send_word(sp, sa, 1'b0, z);
        end
        drop_valid();
        repeat ($urandom_range(0, 39)) @(posedge clk);
      end
      drop_valid();
      drain();
    end

    if (errors == 0 && pose_q.size() == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
